// ===== hdl/dcbe_pkg.sv =====
// Shared types and constants of the dual-channel beat envelope follower.
`default_nettype none

package dcbe_pkg;

    // Coefficient and gain formats
    localparam int COEF_BITS = 16;
    localparam int GAIN_BITS = 12;
    localparam int GAIN_FRAC = 8;
    localparam int OUT_FRAC  = 8;

    // Unity weight in Q0.16, one bit wider than a coefficient
    localparam logic [COEF_BITS:0] COEF_ONE = {1'b1, {COEF_BITS{1'b0}}};

    // Configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_DC_COEFF      = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ENV_COEFF     = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_OVERRIDE_GAIN = 2'd2;

    localparam logic [COEF_BITS-1:0] DC_COEFF_RST      = 16'd66;
    localparam logic [COEF_BITS-1:0] ENV_COEFF_RST     = 16'd1311;
    localparam logic [GAIN_BITS-1:0] OVERRIDE_GAIN_RST = 12'd256;

    // Hue mapping: four degrees per envelope unit
    localparam int             HUE_BITS  = 9;
    localparam int             HUE_SHIFT = 2;
    localparam logic [HUE_BITS-1:0] HUE_LIMIT = 9'd359;
    localparam logic [HUE_BITS-1:0] HUE_BLACK = 9'd10;

    // Configuration registers as seen by the datapath
    typedef struct packed {
        logic [COEF_BITS-1:0] dc_coeff;
        logic [COEF_BITS-1:0] env_coeff;
        logic [GAIN_BITS-1:0] override_gain;
    } t_cfg;

    // Control of the shared multiply-accumulate unit
    typedef struct packed {
        logic mul_en;
        logic acc_clr;
        logic acc_add;
    } t_mac_ctl;

endpackage

`default_nettype wire

// ===== hdl/dcbe_if.sv =====
// Channel interfaces: sample input, result output and configuration write.
`default_nettype none

interface dcbe_in_if #(
    parameter int SAMPLE_BITS = 10
) ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface dcbe_out_if #(
    parameter int OUT_BITS = 18
) ();
    logic                              valid;
    logic                              ready;
    logic                              channel;
    logic [OUT_BITS-1:0]               dc_level;
    logic [OUT_BITS-1:0]               envelope;
    logic [dcbe_pkg::HUE_BITS-1:0]     hue;

    modport source (output valid, output channel, output dc_level, output envelope,
                    output hue, input ready);
    modport sink   (input valid, input channel, input dc_level, input envelope,
                    input hue, output ready);
endinterface

interface dcbe_cfg_if ();
    logic                                 valid;
    logic                                 ready;
    logic [dcbe_pkg::CFG_IDX_BITS-1:0]    index;
    logic [dcbe_pkg::CFG_DATA_BITS-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/dcbe_cfg.sv =====
// Configuration register bank: coefficients and peak override gain.
`default_nettype none

module dcbe_cfg (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    dcbe_cfg_if.sink             i_cfg,
    output dcbe_pkg::t_cfg       o_regs
);

    dcbe_pkg::t_cfg r_regs;

    // Always take a configuration word
    assign i_cfg.ready = 1'b1;
    assign o_regs      = r_regs;

    // Write the addressed register, drop words beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs.dc_coeff      <= dcbe_pkg::DC_COEFF_RST;
            r_regs.env_coeff     <= dcbe_pkg::ENV_COEFF_RST;
            r_regs.override_gain <= dcbe_pkg::OVERRIDE_GAIN_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                dcbe_pkg::REG_DC_COEFF: begin
                    r_regs.dc_coeff <= i_cfg.data[dcbe_pkg::COEF_BITS-1:0];
                end
                dcbe_pkg::REG_ENV_COEFF: begin
                    r_regs.env_coeff <= i_cfg.data[dcbe_pkg::COEF_BITS-1:0];
                end
                dcbe_pkg::REG_OVERRIDE_GAIN: begin
                    r_regs.override_gain <= i_cfg.data[dcbe_pkg::GAIN_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/dcbe_mac.sv =====
// Shared multiplier with registered product and accumulator.
`default_nettype none

module dcbe_mac #(
    parameter int A_BITS = 26,
    parameter int B_BITS = 17
) (
    input  wire                          i_clk,
    input  wire [A_BITS-1:0]             i_op_a,
    input  wire [B_BITS-1:0]             i_op_b,
    input  wire dcbe_pkg::t_mac_ctl      i_ctl,
    output logic [A_BITS+B_BITS-1:0]     o_prod,
    output logic [A_BITS+B_BITS-1:0]     o_acc
);

    logic [A_BITS+B_BITS-1:0] r_prod;
    logic [A_BITS+B_BITS-1:0] r_acc;

    // Register the product, then load or add it into the accumulator
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= (A_BITS+B_BITS)'(i_op_a) * (A_BITS+B_BITS)'(i_op_b);
        end
        if (i_ctl.acc_clr) begin
            r_acc <= r_prod;
        end else if (i_ctl.acc_add) begin
            r_acc <= r_acc + r_prod;
        end
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

`default_nettype wire

// ===== hdl/dual_channel_beat_envelope_core.sv =====
// Top level: sequencer, per-channel state and result register of the envelope follower.
//
// Usage:
//   i_in carries one unsigned ADC sample per word; samples are assigned to the
//   channels in round-robin order, starting with channel 0 after reset.
//   o_out carries one result word per sample: channel, DC level (Q10.8),
//   peak-hold envelope (Q10.8) and hue in degrees.
//   i_cfg writes dc_coeff (index 0), env_coeff (index 1) and override_gain
//   (index 2); it is always ready and should be written only while idle.
// Sequencing:
//   After acceptance, a sample passes through eleven sequencer steps around a
//   single shared multiplier, which performs five multiplies (two per IIR
//   blend and one for the peak compare). i_in stays not ready until the final
//   step loads the result register, so one sample is handled at a time.
// Reset:
//   Synchronous, active low. Clears both averages, both envelopes, the channel
//   counter and the result valid flag; configuration returns to its defaults.
// Back-pressure:
//   The result register holds a word until taken. A new sample is accepted
//   while it waits; the sequencer then holds on its final step until the
//   result register is free.
`default_nettype none

module dual_channel_beat_envelope_core #(
    parameter int SAMPLE_BITS = 10,
    parameter int FRAC_BITS   = 16,
    parameter int CHANNELS    = 2
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    dcbe_in_if.sink            i_in,
    dcbe_out_if.source         o_out,
    dcbe_cfg_if.sink           i_cfg
);

    localparam int STATE_BITS = SAMPLE_BITS + FRAC_BITS;
    localparam int OUT_BITS   = SAMPLE_BITS + dcbe_pkg::OUT_FRAC;
    localparam int MUL_B      = dcbe_pkg::COEF_BITS + 1;
    localparam int PROD_BITS  = STATE_BITS + MUL_B;
    localparam int CH_BITS    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [STATE_BITS-1:0] HUE_THR =
        STATE_BITS'(dcbe_pkg::HUE_LIMIT) << (FRAC_BITS - dcbe_pkg::HUE_SHIFT);
    localparam logic [CH_BITS-1:0] CH_LAST = CH_BITS'(CHANNELS - 1);

    // Sequencer steps
    localparam logic [3:0] STEP_DC_X     = 4'd0;
    localparam logic [3:0] STEP_DC_Y     = 4'd1;
    localparam logic [3:0] STEP_DC_SUM   = 4'd2;
    localparam logic [3:0] STEP_DC_TAKE  = 4'd3;
    localparam logic [3:0] STEP_DEV      = 4'd4;
    localparam logic [3:0] STEP_ENV_X    = 4'd5;
    localparam logic [3:0] STEP_ENV_Y    = 4'd6;
    localparam logic [3:0] STEP_ENV_SUM  = 4'd7;
    localparam logic [3:0] STEP_ENV_TAKE = 4'd8;
    localparam logic [3:0] STEP_GAIN     = 4'd9;
    localparam logic [3:0] STEP_DONE     = 4'd10;

    dcbe_pkg::t_cfg     cfg;
    dcbe_pkg::t_mac_ctl mac_ctl;
    logic [STATE_BITS-1:0] mac_a;
    logic [MUL_B-1:0]      mac_b;
    logic [PROD_BITS-1:0]  mac_prod;
    logic [PROD_BITS-1:0]  mac_acc;

    logic                  r_busy;
    logic [3:0]            r_step;
    logic [CH_BITS-1:0]    r_ch;
    logic [STATE_BITS-1:0] r_dc_avg [CHANNELS];
    logic [STATE_BITS-1:0] r_env_lvl [CHANNELS];

    logic [STATE_BITS-1:0] r_x;
    logic [STATE_BITS-1:0] r_avg;
    logic [STATE_BITS-1:0] r_dev;
    logic [STATE_BITS-1:0] r_env;

    logic                         r_out_valid;
    logic                         r_out_ch;
    logic [OUT_BITS-1:0]          r_out_dc;
    logic [OUT_BITS-1:0]          r_out_env;
    logic [dcbe_pkg::HUE_BITS-1:0] r_out_hue;

    logic [MUL_B-1:0]             dc_comp;
    logic [MUL_B-1:0]             env_comp;
    logic [STATE_BITS-1:0]        blend;
    logic [STATE_BITS-1:0]        n_env;
    logic [dcbe_pkg::HUE_BITS-1:0] n_hue;
    logic [CH_BITS-1:0]           n_ch;
    logic                         in_acc;
    logic                         fire;

    dcbe_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_regs  (cfg)
    );

    dcbe_mac #(
        .A_BITS (STATE_BITS),
        .B_BITS (MUL_B)
    ) u_mac (
        .i_clk  (i_clk),
        .i_op_a (mac_a),
        .i_op_b (mac_b),
        .i_ctl  (mac_ctl),
        .o_prod (mac_prod),
        .o_acc  (mac_acc)
    );

    // Complementary weights and blend result
    assign dc_comp  = dcbe_pkg::COEF_ONE - MUL_B'(cfg.dc_coeff);
    assign env_comp = dcbe_pkg::COEF_ONE - MUL_B'(cfg.env_coeff);
    assign blend    = mac_acc[dcbe_pkg::COEF_BITS +: STATE_BITS];

    // Peak override: deviation wins when it exceeds gain times envelope
    assign n_env = (PROD_BITS'({r_dev, {dcbe_pkg::GAIN_FRAC{1'b0}}}) > mac_prod)
                   ? r_dev : r_env;

    // Hue: four times the envelope, blacked out above the limit
    assign n_hue = (n_env > HUE_THR) ? dcbe_pkg::HUE_BLACK
                 : n_env[FRAC_BITS-dcbe_pkg::HUE_SHIFT +: dcbe_pkg::HUE_BITS];

    assign n_ch = (r_ch == CH_LAST) ? '0 : r_ch + 1'b1;

    // Handshakes
    assign i_in.ready = !r_busy;
    assign in_acc     = i_in.valid && !r_busy;
    assign fire       = r_busy && (r_step == STEP_DONE) && (!r_out_valid || o_out.ready);

    // Steer operands into the shared multiplier
    always_comb begin
        mac_a   = '0;
        mac_b   = '0;
        mac_ctl = '0;
        if (r_busy) begin
            case (r_step)
                STEP_DC_X: begin
                    mac_a          = r_x;
                    mac_b          = MUL_B'(cfg.dc_coeff);
                    mac_ctl.mul_en = 1'b1;
                end
                STEP_DC_Y: begin
                    mac_a           = r_dc_avg[r_ch];
                    mac_b           = dc_comp;
                    mac_ctl.mul_en  = 1'b1;
                    mac_ctl.acc_clr = 1'b1;
                end
                STEP_DC_SUM: begin
                    mac_ctl.acc_add = 1'b1;
                end
                STEP_ENV_X: begin
                    mac_a          = r_dev;
                    mac_b          = MUL_B'(cfg.env_coeff);
                    mac_ctl.mul_en = 1'b1;
                end
                STEP_ENV_Y: begin
                    mac_a           = r_env_lvl[r_ch];
                    mac_b           = env_comp;
                    mac_ctl.mul_en  = 1'b1;
                    mac_ctl.acc_clr = 1'b1;
                end
                STEP_ENV_SUM: begin
                    mac_ctl.acc_add = 1'b1;
                end
                STEP_GAIN: begin
                    mac_a          = r_env;
                    mac_b          = MUL_B'(cfg.override_gain);
                    mac_ctl.mul_en = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Advance the sequencer, update channel state, fill the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= STEP_DC_X;
            r_ch        <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < CHANNELS; k++) begin
                r_dc_avg[k]  <= '0;
                r_env_lvl[k] <= '0;
            end
        end else begin
            if (in_acc) begin
                r_busy <= 1'b1;
                r_step <= STEP_DC_X;
            end else if (r_busy && (r_step != STEP_DONE)) begin
                r_step <= r_step + 4'd1;
            end else if (fire) begin
                r_busy          <= 1'b0;
                r_dc_avg[r_ch]  <= r_avg;
                r_env_lvl[r_ch] <= n_env;
                r_ch            <= n_ch;
            end

            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath holding registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x <= {i_in.sample, {FRAC_BITS{1'b0}}};
        end
        if (r_busy && (r_step == STEP_DC_TAKE)) begin
            r_avg <= blend;
        end
        if (r_busy && (r_step == STEP_DEV)) begin
            r_dev <= (r_x >= r_avg) ? (r_x - r_avg) : (r_avg - r_x);
        end
        if (r_busy && (r_step == STEP_ENV_TAKE)) begin
            r_env <= blend;
        end
        if (fire) begin
            r_out_ch  <= r_ch[0];
            r_out_dc  <= r_avg[FRAC_BITS-dcbe_pkg::OUT_FRAC +: OUT_BITS];
            r_out_env <= n_env[FRAC_BITS-dcbe_pkg::OUT_FRAC +: OUT_BITS];
            r_out_hue <= n_hue;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.channel  = r_out_ch;
    assign o_out.dc_level = r_out_dc;
    assign o_out.envelope = r_out_env;
    assign o_out.hue      = r_out_hue;

    // Checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("sample accepted while sequencer should be busy");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_step <= STEP_DONE))
        else $error("sequencer step out of range");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_busy && (r_step == STEP_DONE)))
        else $error("result word loaded outside the final step");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.hue <= dcbe_pkg::HUE_LIMIT))
        else $error("hue above limit");

endmodule

`default_nettype wire

// ===== tb/dual_channel_beat_envelope_core_tb.sv =====
// Self-checking testbench of the dual-channel beat envelope follower core.
module dual_channel_beat_envelope_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dcbe_pkg::*;

    localparam int SAMPLE_W = 10;
    localparam int FRAC_W   = 16;
    localparam int CH_COUNT = 2;
    localparam int STATE_W  = SAMPLE_W + FRAC_W;
    localparam int OUT_W    = SAMPLE_W + OUT_FRAC;
    localparam int PHASE_ITEMS = 250;
    localparam int PHASES      = 8;
    localparam int SETTLE_CYCLES = 24;

    typedef struct packed {
        logic                channel;
        logic [OUT_W-1:0]    dc_level;
        logic [OUT_W-1:0]    envelope;
        logic [HUE_BITS-1:0] hue;
    } beat_result_t;

    // Envelope predictor plus the queue of results it still owes
    class envelope_scoreboard;
        bit [COEF_BITS-1:0] dc_coeff;
        bit [COEF_BITS-1:0] env_coeff;
        bit [GAIN_BITS-1:0] override_gain;
        bit [STATE_W-1:0]   dc_avg [CH_COUNT];
        bit [STATE_W-1:0]   env_level [CH_COUNT];
        int                 next_ch;
        beat_result_t       owed_q [$];
        int mismatches;
        int samples_seen;
        int results_checked;
        int reg_writes;
        int peak_overrides;
        int black_hues;

        function new();
            dc_coeff      = DC_COEFF_RST;
            env_coeff     = ENV_COEFF_RST;
            override_gain = OVERRIDE_GAIN_RST;
            foreach (dc_avg[k]) begin
                dc_avg[k]    = '0;
                env_level[k] = '0;
            end
            next_ch = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            reg_writes++;
            case (idx)
                REG_DC_COEFF:      dc_coeff = data[COEF_BITS-1:0];
                REG_ENV_COEFF:     env_coeff = data[COEF_BITS-1:0];
                REG_OVERRIDE_GAIN: override_gain = data[GAIN_BITS-1:0];
                default: ;
            endcase
        endfunction

        // First-order IIR step: (x*c + y*(1-c)) in Q0.16, truncated
        function bit [63:0] iir_blend(bit [63:0] x, bit [63:0] y, bit [63:0] c);
            bit [63:0] acc;
            acc = x * c + y * (64'(COEF_ONE) - c);
            return (acc >> COEF_BITS) & ((64'd1 << STATE_W) - 64'd1);
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] s);
            bit [63:0]    x, avg, dev, env, scaled;
            int           ch;
            beat_result_t r;
            ch  = next_ch;
            x   = 64'(s) << FRAC_W;
            avg = iir_blend(x, dc_avg[ch], dc_coeff);
            dev = (x >= avg) ? x - avg : avg - x;
            env = iir_blend(dev, env_level[ch], env_coeff);
            // Peak hold: jump to the deviation once it beats gain * envelope
            if ((dev << GAIN_FRAC) > 64'(override_gain) * env) begin
                env = dev;
                peak_overrides++;
            end
            dc_avg[ch]    = avg[STATE_W-1:0];
            env_level[ch] = env[STATE_W-1:0];
            next_ch       = (ch + 1 >= CH_COUNT) ? 0 : ch + 1;
            r.channel  = ch[0];
            r.dc_level = avg[STATE_W-1 -: OUT_W];
            r.envelope = env[STATE_W-1 -: OUT_W];
            // Hue clamps to black on the exact value, fraction included
            scaled = env << HUE_SHIFT;
            if (scaled > (64'(HUE_LIMIT) << FRAC_W)) begin
                r.hue = HUE_BLACK;
                black_hues++;
            end else begin
                r.hue = scaled[FRAC_W +: HUE_BITS];
            end
            owed_q.push_back(r);
            samples_seen++;
        endfunction

        function void compare_field(string field, longint unsigned want, longint unsigned got);
            if (want != got) begin
                mismatches++;
                $error("%s: expected %0d, actual %0d", field, want, got);
            end
        endfunction

        function void check_result(beat_result_t got);
            beat_result_t want;
            results_checked++;
            if (owed_q.size() == 0) begin
                mismatches++;
                $error("unexpected result word: channel %0d dc_level %0d envelope %0d hue %0d",
                       got.channel, got.dc_level, got.envelope, got.hue);
                return;
            end
            want = owed_q.pop_front();
            compare_field("channel", want.channel, got.channel);
            compare_field("dc_level", want.dc_level, got.dc_level);
            compare_field("envelope", want.envelope, got.envelope);
            compare_field("hue", want.hue, got.hue);
        endfunction

        function int outstanding();
            return owed_q.size();
        endfunction

        function void check_leftover();
            if (owed_q.size() != 0) begin
                mismatches += owed_q.size();
                $error("%0d expected result words never arrived", owed_q.size());
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   idle_pct;
    int   stall_pct;
    envelope_scoreboard sb;
    beat_result_t seen;

    dcbe_in_if #(.SAMPLE_BITS(SAMPLE_W)) in_if ();
    dcbe_out_if #(.OUT_BITS(OUT_W))      out_if ();
    dcbe_cfg_if                          cfg_if ();

    dual_channel_beat_envelope_core #(
        .SAMPLE_BITS(SAMPLE_W),
        .FRAC_BITS  (FRAC_W),
        .CHANNELS   (CH_COUNT)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if),
        .i_cfg  (cfg_if)
    );

    always #6 i_clk = ~i_clk;

    // Watch every handshake at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                sb.write_reg(cfg_if.index, cfg_if.data);
            end
            if (in_if.valid && in_if.ready) begin
                sb.note_sample(in_if.sample);
            end
            if (out_if.valid && out_if.ready) begin
                seen.channel  = out_if.channel;
                seen.dc_level = out_if.dc_level;
                seen.envelope = out_if.envelope;
                seen.hue      = out_if.hue;
                sb.check_result(seen);
            end
        end
    end

    // Receiver: stall at random per the current pressure setting
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready = ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Hand one sample word over; enter and leave on a falling edge
    task automatic send_sample(logic [SAMPLE_W-1:0] value);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid  = 1'b1;
        in_if.sample = value;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = data;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    // Drop valid and hold until every owed result has come back
    task automatic drain_results();
        in_if.valid = 1'b0;
        while (sb.outstanding() != 0) @(negedge i_clk);
    endtask

    task automatic load_setting(int dc, int env, int gain_word);
        write_register(REG_DC_COEFF, dc[CFG_DATA_BITS-1:0]);
        write_register(REG_ENV_COEFF, env[CFG_DATA_BITS-1:0]);
        write_register(REG_OVERRIDE_GAIN, gain_word[CFG_DATA_BITS-1:0]);
    endtask

    // Random samples in bursts of one signal shape; pause once midway
    task automatic stream_samples(int count);
        int shape, base, amp, v;
        for (int k = 0; k < count; k++) begin
            if (k % 32 == 0) begin
                shape = $urandom_range(0, 3);
                base  = $urandom_range(0, 1023);
                amp   = $urandom_range(1, 64);
            end
            if (k == count / 2) begin
                drain_results();
            end
            case (shape)
                0: v = $urandom_range(0, 1023);
                // quiet hum around a level
                1: v = base + $urandom_range(0, 2 * amp) - amp;
                // beat: short loud hit, then near-quiet
                2: v = (k % 16 < 2) ? base + 8 * amp - 256 : base + $urandom_range(0, amp / 4);
                default: v = $urandom_range(0, 1) ? 1023 - $urandom_range(0, 1)
                                                  : $urandom_range(0, 1);
            endcase
            if (v < 0) v = 0;
            if (v > 1023) v = 1023;
            send_sample(v[SAMPLE_W-1:0]);
        end
        in_if.valid = 1'b0;
    endtask

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int directed [] = '{1023, 1023, 0, 0, 512, 512, 1, 1022, 682, 341, 3, 3, 3, 3, 1023, 0};
        int gain_word;
        sb = new();
        i_rst_n      = 1'b0;
        idle_pct     = 0;
        stall_pct    = 0;
        in_if.valid  = 1'b0;
        in_if.sample = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = REG_DC_COEFF;
        cfg_if.data  = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: extremes, bit patterns and steady input at reset defaults
        foreach (directed[k]) send_sample(directed[k][SAMPLE_W-1:0]);
        drain_results();

        // Zero gain: any nonzero deviation overrides; settle to zero deviation
        load_setting(65535, ENV_COEFF_RST, 0);
        repeat (6) send_sample('0);
        send_sample(10'd700);
        send_sample(10'd700);
        drain_results();

        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 80; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 80; end
                default: begin idle_pct = 36; stall_pct = 36; end
            endcase
            case (p)
                0: load_setting(DC_COEFF_RST, ENV_COEFF_RST, OVERRIDE_GAIN_RST);
                1: load_setting(65535, 65535, 4095);
                2: load_setting(1, 1, 0);
                // frozen averages: pure peak hold
                3: load_setting(0, 0, OVERRIDE_GAIN_RST);
                default: begin
                    gain_word = ($urandom_range(0, 15) << GAIN_BITS) | $urandom_range(0, 4095);
                    load_setting($urandom_range(0, 1) ? $urandom_range(1, 2047)
                                                      : $urandom_range(1, 65535),
                                 $urandom_range(1, 65535), gain_word);
                end
            endcase
            stream_samples(PHASE_ITEMS);
            drain_results();
        end

        idle_pct  = 0;
        stall_pct = 0;
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        sb.check_leftover();
        $display("Ran %0d samples through %0d register writes; %0d result words compared.",
                 sb.samples_seen, sb.reg_writes, sb.results_checked);
        $display("Peak hold fired %0d times, hue clamped to black %0d times, %0d mismatches.",
                 sb.peak_overrides, sb.black_hues, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
